FILE: rtl/core/mrps_pkg.sv
package mrps_pkg;

  localparam int PATTERN_FIELDS = 5;
  localparam int RESULT_LIMIT   = 25;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_ROTATE = 2'd2;
  localparam logic [1:0] FUNC_SEARCH = 2'd3;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_ROTATE = 2'd2;
  localparam logic [1:0] KIND_SEARCH = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic [1:0]         quarter_turns;
    logic [2:0]         pattern_len;
    logic signed [31:0] pattern_0;
    logic signed [31:0] pattern_1;
    logic signed [31:0] pattern_2;
    logic signed [31:0] pattern_3;
    logic signed [31:0] pattern_4;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] read_value;
    logic               found;
    logic [2:0]         match_row;
    logic [2:0]         match_col;
    logic               last;
  } out_t;

  // Classified command. The pattern is stored newest-first, so that word k
  // lines up with the k-th most recent matrix word of a row scan.
  typedef struct packed {
    logic [1:0]                          func;
    logic [2:0]                          row;
    logic [2:0]                          col;
    logic                                in_bounds;
    logic [31:0]                         value;
    logic [1:0]                          turns;
    logic                                len_ok;
    logic [2:0]                          len;
    logic [PATTERN_FIELDS-1:0][31:0]     rpat;
    logic [PATTERN_FIELDS-1:0]           pmask;
  } cmd_t;

  function automatic out_t make_result(logic [1:0] kind, logic [31:0] rv, logic found,
                                       logic [2:0] mr, logic [2:0] mc, logic last);
    out_t r;
    r.kind       = kind;
    r.read_value = rv;
    r.found      = found;
    r.match_row  = mr;
    r.match_col  = mc;
    r.last       = last;
    return r;
  endfunction

endpackage

FILE: rtl/core/mrps_front.sv
module mrps_front #(
  parameter int SIDE        = 5,
  parameter int MAX_PATTERN = 5
) (
  input  mrps_pkg::in_t  in_i,
  output mrps_pkg::cmd_t cmd_o
);
  import mrps_pkg::*;

  logic [PATTERN_FIELDS-1:0][31:0] pats;
  logic                            len_ok;

  assign pats = {in_i.pattern_4, in_i.pattern_3, in_i.pattern_2,
                 in_i.pattern_1, in_i.pattern_0};

  assign len_ok = (in_i.pattern_len != 3'd0) &&
                  (int'(in_i.pattern_len) <= MAX_PATTERN) &&
                  (int'(in_i.pattern_len) <= PATTERN_FIELDS) &&
                  (int'(in_i.pattern_len) <= SIDE);

  always_comb begin
    cmd_o.func      = in_i.func;
    cmd_o.row       = in_i.row;
    cmd_o.col       = in_i.col;
    cmd_o.in_bounds = (int'(in_i.row) < SIDE) && (int'(in_i.col) < SIDE);
    cmd_o.value     = in_i.value;
    cmd_o.turns     = in_i.quarter_turns;
    cmd_o.len_ok    = len_ok;
    cmd_o.len       = in_i.pattern_len;
    for (int k = 0; k < PATTERN_FIELDS; k++) begin
      cmd_o.rpat[k]  = '0;
      cmd_o.pmask[k] = 1'b0;
      if (len_ok && (k < int'(in_i.pattern_len))) begin
        cmd_o.rpat[k]  = pats[3'(int'(in_i.pattern_len) - 1 - k)];
        cmd_o.pmask[k] = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mrps_fifo.sv
module mrps_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mrps_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mrps_pkg::cmd_t pop_data_o
);
  import mrps_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  cmd_t            entries_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CNTW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNTW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/mrps_back.sv
module mrps_back #(
  parameter int SIDE        = 5,
  parameter int MAX_PATTERN = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  mrps_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mrps_pkg::out_t out_o
);
  import mrps_pkg::*;

  localparam int N    = SIDE * SIDE;
  localparam int AW   = $clog2(N);
  localparam int MW   = $clog2(2 * N);
  localparam int CW   = $clog2(SIDE);
  localparam int HW   = $clog2(RESULT_LIMIT + 1);
  localparam int LM0  = (MAX_PATTERN < PATTERN_FIELDS) ? MAX_PATTERN : PATTERN_FIELDS;
  localparam int LMAX = (LM0 < SIDE) ? LM0 : SIDE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ROT,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_e;

  // Two banks: a rotation copies the active bank into the other one.
  logic [31:0] mem [2 * N];
  logic [31:0] rdata_q;
  logic        re, we;
  logic [MW-1:0] raddr, waddr;
  logic [31:0] wdata;

  state_e          state_q, state_d;
  logic            bank_q, bank_d;
  cmd_t            cmd_q, cmd_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            rv_q, rv_d;
  logic            more_q, more_d;
  logic [AW-1:0]   ia_q, ia_d;
  logic [CW-1:0]   ir_q, ir_d, ic_q, ic_d;
  logic            wv_q, wv_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic [CW-1:0]   pr_q, pr_d, pc_q, pc_d;
  logic [LMAX-1:0][31:0] sh_q, sh_d;
  logic            pv_q, pv_d;
  logic [CW-1:0]   prow_q, prow_d, pcol_q, pcol_d;
  logic [HW-1:0]   hits_q, hits_d;

  logic [LMAX-1:0][31:0] shn;
  logic [LMAX-1:0]       eqv;
  logic                  hit, stall, slot_free, last_elem;
  logic [CW-1:0]         mcol;

  function automatic logic [AW-1:0] lin(logic [CW-1:0] r, logic [CW-1:0] c);
    return AW'(int'(r) * SIDE + int'(c));
  endfunction

  function automatic logic [MW-1:0] maddr(logic bank, logic [AW-1:0] idx);
    return MW'(idx) + (bank ? MW'(N) : MW'(0));
  endfunction

  function automatic logic [AW-1:0] src_idx(logic [CW-1:0] r, logic [CW-1:0] c,
                                            logic [1:0] t);
    logic [CW-1:0] rr;
    logic [CW-1:0] cc;
    case (t)
      2'd1: begin
        rr = CW'(SIDE - 1 - int'(c));
        cc = r;
      end
      2'd2: begin
        rr = CW'(SIDE - 1 - int'(r));
        cc = CW'(SIDE - 1 - int'(c));
      end
      default: begin
        rr = c;
        cc = CW'(SIDE - 1 - int'(r));
      end
    endcase
    return lin(rr, cc);
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Window ending at the word that arrives this cycle, newest word first.
  always_comb begin
    for (int k = 0; k < LMAX; k++) begin
      shn[k] = (k == 0) ? rdata_q : sh_q[(k == 0) ? 0 : k - 1];
      eqv[k] = (shn[k] == cmd_q.rpat[k]) || !cmd_q.pmask[k];
    end
  end

  assign hit       = rv_q && (&eqv) && (int'(pc_q) + 1 >= int'(cmd_q.len));
  assign mcol      = CW'(int'(pc_q) + 1 - int'(cmd_q.len));
  assign last_elem = (pr_q == CW'(SIDE - 1)) && (pc_q == CW'(SIDE - 1));
  // A new match can only be taken once the previous one has gone out.
  assign stall     = hit && pv_q && !slot_free;

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rv_d        = rv_q;
    more_d      = more_q;
    ia_d        = ia_q;
    ir_d        = ir_q;
    ic_d        = ic_q;
    wv_d        = wv_q;
    wa_d        = wa_q;
    pr_d        = pr_q;
    pc_d        = pc_q;
    sh_d        = sh_q;
    pv_d        = pv_q;
    prow_d      = prow_q;
    pcol_d      = pcol_q;
    hits_d      = hits_q;
    cmd_ready_o = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.func)
            FUNC_WRITE: begin
              we      = cmd_i.in_bounds;
              waddr   = maddr(bank_q, lin(CW'(cmd_i.row), CW'(cmd_i.col)));
              wdata   = cmd_i.value;
              res_d   = make_result(KIND_WRITE, '0, 1'b0, '0, '0, 1'b1);
              state_d = ST_EMIT;
            end
            FUNC_READ: begin
              re      = cmd_i.in_bounds;
              raddr   = maddr(bank_q, lin(CW'(cmd_i.row), CW'(cmd_i.col)));
              state_d = ST_READ;
            end
            FUNC_ROTATE: begin
              if (cmd_i.turns == 2'd0) begin
                res_d   = make_result(KIND_ROTATE, '0, 1'b0, '0, '0, 1'b1);
                state_d = ST_EMIT;
              end else begin
                ia_d    = '0;
                ir_d    = '0;
                ic_d    = '0;
                more_d  = 1'b1;
                wv_d    = 1'b0;
                state_d = ST_ROT;
              end
            end
            FUNC_SEARCH: begin
              if (cmd_i.len_ok) begin
                ia_d    = '0;
                more_d  = 1'b1;
                rv_d    = 1'b0;
                pr_d    = '0;
                pc_d    = '0;
                pv_d    = 1'b0;
                hits_d  = '0;
                state_d = ST_SCAN;
              end else begin
                res_d   = make_result(KIND_SEARCH, '0, 1'b0, '0, '0, 1'b1);
                state_d = ST_EMIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ: begin
        res_d   = make_result(KIND_READ, cmd_q.in_bounds ? rdata_q : '0, 1'b0, '0, '0,
                              1'b1);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_ROT: begin
        // Read a source word each cycle and write it in the following cycle.
        wv_d = more_q;
        if (more_q) begin
          re    = 1'b1;
          raddr = maddr(bank_q, src_idx(ir_q, ic_q, cmd_q.turns));
          wa_d  = ia_q;
          ia_d  = ia_q + AW'(1);
          if (ic_q == CW'(SIDE - 1)) begin
            ic_d = '0;
            ir_d = ir_q + CW'(1);
          end else begin
            ic_d = ic_q + CW'(1);
          end
          if (ia_q == AW'(N - 1)) begin
            more_d = 1'b0;
          end
        end
        if (wv_q) begin
          we    = 1'b1;
          waddr = maddr(!bank_q, wa_q);
          wdata = rdata_q;
          if (wa_q == AW'(N - 1)) begin
            bank_d  = !bank_q;
            res_d   = make_result(KIND_ROTATE, '0, 1'b0, '0, '0, 1'b1);
            state_d = ST_EMIT;
          end
        end
      end

      ST_SCAN: begin
        if (!stall && more_q) begin
          re    = 1'b1;
          raddr = maddr(bank_q, ia_q);
          ia_d  = ia_q + AW'(1);
          if (ia_q == AW'(N - 1)) begin
            more_d = 1'b0;
          end
        end
        // On a stall the read register is not reloaded, so its word waits.
        rv_d = stall ? 1'b1 : re;
        if (rv_q && !stall) begin
          sh_d = shn;
          if (pc_q == CW'(SIDE - 1)) begin
            pc_d = '0;
            pr_d = pr_q + CW'(1);
          end else begin
            pc_d = pc_q + CW'(1);
          end
          if (hit) begin
            // The latest match is held back until it is known whether it is last.
            if (pv_q) begin
              out_d       = make_result(KIND_SEARCH, '0, 1'b1, 3'(prow_q), 3'(pcol_q), 1'b0);
              out_valid_d = 1'b1;
            end
            pv_d   = 1'b1;
            prow_d = pr_q;
            pcol_d = mcol;
            hits_d = hits_q + HW'(1);
          end
          if (last_elem || (hit && (hits_q == HW'(RESULT_LIMIT - 1)))) begin
            rv_d    = 1'b0;
            more_d  = 1'b0;
            state_d = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (slot_free) begin
          out_d       = pv_q ?
                        make_result(KIND_SEARCH, '0, 1'b1, 3'(prow_q), 3'(pcol_q), 1'b1) :
                        make_result(KIND_SEARCH, '0, 1'b0, '0, '0, 1'b1);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      more_q      <= 1'b0;
      wv_q        <= 1'b0;
      pv_q        <= 1'b0;
      hits_q      <= '0;
      ia_q        <= '0;
      ir_q        <= '0;
      ic_q        <= '0;
      wa_q        <= '0;
      pr_q        <= '0;
      pc_q        <= '0;
      prow_q      <= '0;
      pcol_q      <= '0;
      cmd_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      sh_q        <= '0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      more_q      <= more_d;
      wv_q        <= wv_d;
      pv_q        <= pv_d;
      hits_q      <= hits_d;
      ia_q        <= ia_d;
      ir_q        <= ir_d;
      ic_q        <= ic_d;
      wa_q        <= wa_d;
      pr_q        <= pr_d;
      pc_q        <= pc_d;
      prow_q      <= prow_d;
      pcol_q      <= pcol_d;
      cmd_q       <= cmd_d;
      res_q       <= res_d;
      out_q       <= out_d;
      sh_q        <= sh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/matrix_rotate_and_row_pattern_search_unit.sv
// A write or a read gives a single result once the transaction is accepted.
// Rotate moves one word per cycle through the single memory read port; a search
// scans up to SIDE*SIDE words, one per cycle while the result output does not
// stall, and its results wait while the output is stalled.
// Up to two further transactions are queued while one executes.
// Reset clears all control state; matrix contents stay undefined until written.
module matrix_rotate_and_row_pattern_search_unit #(
  parameter int SIDE        = 5,
  parameter int MAX_PATTERN = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mrps_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mrps_pkg::out_t out_data_o
);
  import mrps_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_ready;

  mrps_front #(
    .SIDE        (SIDE),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .in_i  (in_data_i),
    .cmd_o (front_cmd)
  );

  mrps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_cmd)
  );

  mrps_back #(
    .SIDE        (SIDE),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule
